[hw/rtl/crc32e_pkg.sv]
package crc32e_pkg;

    // Register indexes of the configuration port
    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_POLYNOMIAL  = 3'd0;
    localparam t_cfg_index CFG_REFLECT_IN  = 3'd1;
    localparam t_cfg_index CFG_REFLECT_OUT = 3'd2;
    localparam t_cfg_index CFG_START_VALUE = 3'd3;
    localparam t_cfg_index CFG_XOR_OUT     = 3'd4;

    localparam int CFG_DATA_W = 32;
    localparam int CRC_W      = 32;
    localparam int BYTE_W     = 8;

    // Reset values of the configuration registers
    localparam logic [CRC_W-1:0] POLY_RESET  = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] START_RESET = 32'h0000_0000;
    localparam logic [CRC_W-1:0] XOR_RESET   = 32'h0000_0000;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic             reflect_in;
        logic             reflect_out;
        logic [CRC_W-1:0] start_value;
        logic [CRC_W-1:0] xor_out;
    } t_cfg;

    // Bit reversal, pure wiring
    function automatic logic [CRC_W-1:0] bit_rev(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    // One byte folded into the CRC: eight XOR-shift steps
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly,
        input logic              refl
    );
        logic [CRC_W-1:0] r;
        logic [CRC_W-1:0] rpoly;
        rpoly = bit_rev(poly);
        if (refl) begin
            r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
            for (int k = 0; k < BYTE_W; k++) begin
                r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
            end
        end else begin
            r = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
            for (int k = 0; k < BYTE_W; k++) begin
                r = r[CRC_W-1] ? ((r << 1) ^ poly) : (r << 1);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/crc32e_if.sv]
// Byte request channel
interface crc32e_in_if;
    logic                           valid;
    logic                           ready;
    logic [crc32e_pkg::BYTE_W-1:0]  data_byte;
    logic                           first_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

// Checksum result channel
interface crc32e_out_if;
    logic                          valid;
    logic                          ready;
    logic [crc32e_pkg::CRC_W-1:0]  checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

[hw/rtl/crc32e_cfg.sv]
module crc32e_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  crc32e_pkg::t_cfg_index             i_cfg_index,
    input  logic [crc32e_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output crc32e_pkg::t_cfg                   o_cfg
);

    crc32e_pkg::t_cfg r_cfg;

    // Register file, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial  <= crc32e_pkg::POLY_RESET;
            r_cfg.reflect_in  <= 1'b0;
            r_cfg.reflect_out <= 1'b0;
            r_cfg.start_value <= crc32e_pkg::START_RESET;
            r_cfg.xor_out     <= crc32e_pkg::XOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crc32e_pkg::CFG_POLYNOMIAL:  r_cfg.polynomial  <= i_cfg_data;
                crc32e_pkg::CFG_REFLECT_IN:  r_cfg.reflect_in  <= i_cfg_data[0];
                crc32e_pkg::CFG_REFLECT_OUT: r_cfg.reflect_out <= i_cfg_data[0];
                crc32e_pkg::CFG_START_VALUE: r_cfg.start_value <= i_cfg_data;
                crc32e_pkg::CFG_XOR_OUT:     r_cfg.xor_out     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/crc32e_fold.sv]
module crc32e_fold (
    input  crc32e_pkg::t_cfg                 i_cfg,
    input  logic [crc32e_pkg::CRC_W-1:0]     i_crc,
    input  logic [crc32e_pkg::BYTE_W-1:0]    i_data,
    input  logic                             i_first,
    output logic [crc32e_pkg::CRC_W-1:0]     o_crc,
    output logic [crc32e_pkg::CRC_W-1:0]     o_checksum
);

    logic [crc32e_pkg::CRC_W-1:0] seed;
    logic [crc32e_pkg::CRC_W-1:0] folded;

    // Start value is loaded as is, never reflected
    assign seed   = i_first ? i_cfg.start_value : i_crc;
    assign folded = crc32e_pkg::fold_byte(seed, i_data, i_cfg.polynomial,
                                          i_cfg.reflect_in);
    assign o_crc  = folded;

    // Finish: reverse when the reflect flags differ, then apply the mask
    always_comb begin
        if (i_cfg.reflect_in != i_cfg.reflect_out) begin
            o_checksum = crc32e_pkg::bit_rev(folded) ^ i_cfg.xor_out;
        end else begin
            o_checksum = folded ^ i_cfg.xor_out;
        end
    end

endmodule

[hw/rtl/crc32_configurable_engine.sv]
// A byte accepted into the input register folds into the CRC register when it
//   advances; a last byte's checksum is then registered and offered for reading.
// One byte per cycle unless a last byte waits; the 8-step fold loop is combinational.
// A last byte waits in the input register only while a checksum is unread.
// Reset (synchronous, active low): CRC register 0, both channels empty,
//   configuration back to polynomial 0x04C11DB7, all other registers 0.
module crc32_configurable_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    crc32e_in_if.sink                          i_byte,
    crc32e_out_if.source                       o_crc,
    input  logic                               i_cfg_we,
    input  crc32e_pkg::t_cfg_index             i_cfg_index,
    input  logic [crc32e_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    crc32e_pkg::t_cfg cfg;

    logic                             r_in_valid;
    logic [crc32e_pkg::BYTE_W-1:0]    r_in_data;
    logic                             r_in_first;
    logic                             r_in_last;
    logic [crc32e_pkg::CRC_W-1:0]     r_crc;
    logic                             r_out_valid;
    logic [crc32e_pkg::CRC_W-1:0]     r_out_csum;

    logic [crc32e_pkg::CRC_W-1:0]     n_crc;
    logic [crc32e_pkg::CRC_W-1:0]     n_csum;
    logic                             out_free;
    logic                             advance;
    logic                             in_take;

    crc32e_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crc32e_fold u_fold (
        .i_cfg      (cfg),
        .i_crc      (r_crc),
        .i_data     (r_in_data),
        .i_first    (r_in_first),
        .o_crc      (n_crc),
        .o_checksum (n_csum)
    );

    // Flow control: only a last byte needs room in the result register
    assign out_free     = !r_out_valid || o_crc.ready;
    assign advance      = r_in_valid && (!r_in_last || out_free);
    assign i_byte.ready = !r_in_valid || advance;
    assign in_take      = i_byte.valid && i_byte.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data  <= i_byte.data_byte;
            r_in_first <= i_byte.first_byte;
            r_in_last  <= i_byte.last_byte;
        end
    end

    // CRC state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '0;
        end else if (advance) begin
            r_crc <= n_crc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_crc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_csum <= n_csum;
        end
    end

    assign o_crc.valid    = r_out_valid;
    assign o_crc.checksum = r_out_csum;

endmodule

[hw/rtl/crc32e_checker.sv]
module crc32e_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [crc32e_pkg::CRC_W-1:0]    i_out_checksum
);

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Requests are only held back by an unread checksum
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("request stalled without a pending checksum");

    // With the result channel empty an offered request is taken
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_out_valid) |-> i_in_ready)
        else $error("request refused with an empty result channel");

    // A pending checksum stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("checksum withdrawn before taken");

    // A pending checksum keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_checksum))
        else $error("checksum changed while stalled");

endmodule

bind crc32_configurable_engine crc32e_checker u_crc32e_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_byte.valid),
    .i_in_ready     (i_byte.ready),
    .i_out_valid    (o_crc.valid),
    .i_out_ready    (o_crc.ready),
    .i_out_checksum (o_crc.checksum)
);

[bench/crc32_configurable_engine_tb.sv]
`timescale 1ns / 100ps

module crc32_configurable_engine_tb;

    localparam int                     SETTLE_CYCLES  = 6;
    localparam int                     BYTES_PER_SET  = 200;
    localparam int                     CONFIG_SETS    = 8;
    localparam crc32e_pkg::t_cfg_index CFG_INDEX_TOP  = '1;

    // Receiver pacing modes
    typedef enum int {
        PACE_OPEN,
        PACE_MOSTLY,
        PACE_SPARSE,
        PACE_TOGGLE
    } t_pace;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    crc32e_pkg::t_cfg_index            i_cfg_index;
    logic [crc32e_pkg::CFG_DATA_W-1:0] i_cfg_data;

    crc32e_in_if  byte_if ();
    crc32e_out_if crc_if ();

    crc32_configurable_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_crc       (crc_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted state and checksums still owed by the block
    crc32e_pkg::t_cfg             cfg_shadow;
    logic [crc32e_pkg::CRC_W-1:0] crc_state;
    logic [crc32e_pkg::CRC_W-1:0] checksum_due[$];

    int bytes_sent;
    int checksums_seen;
    int cfg_writes;
    int mismatches;
    int burst_left;
    int stall_request;
    bit sender_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("crc32_configurable_engine_tb: FAIL");
        $finish;
    end

    function automatic logic [crc32e_pkg::CRC_W-1:0] mirror32(
        input logic [crc32e_pkg::CRC_W-1:0] v
    );
        logic [crc32e_pkg::CRC_W-1:0] r;
        for (int k = 0; k < crc32e_pkg::CRC_W; k++) begin
            r[k] = v[crc32e_pkg::CRC_W-1-k];
        end
        return r;
    endfunction

    function automatic crc32e_pkg::t_cfg make_cfg(
        input logic [crc32e_pkg::CRC_W-1:0] poly,
        input logic                         rin,
        input logic                         rout,
        input logic [crc32e_pkg::CRC_W-1:0] init,
        input logic [crc32e_pkg::CRC_W-1:0] mask
    );
        crc32e_pkg::t_cfg c;
        c.polynomial  = poly;
        c.reflect_in  = rin;
        c.reflect_out = rout;
        c.start_value = init;
        c.xor_out     = mask;
        return c;
    endfunction

    // Predictor: follows every accepted request and configuration write
    always @(posedge i_clk) begin : crc_predictor
        logic [crc32e_pkg::CRC_W-1:0] rpoly;
        logic [crc32e_pkg::CRC_W-1:0] sum;
        if (!i_rst_n) begin
            cfg_shadow = make_cfg(crc32e_pkg::POLY_RESET, 1'b0, 1'b0,
                                  crc32e_pkg::START_RESET, crc32e_pkg::XOR_RESET);
            crc_state  = '0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                if (byte_if.first_byte) crc_state = cfg_shadow.start_value;
                if (cfg_shadow.reflect_in) begin
                    rpoly = mirror32(cfg_shadow.polynomial);
                    crc_state ^= {24'h0, byte_if.data_byte};
                    for (int k = 0; k < crc32e_pkg::BYTE_W; k++) begin
                        crc_state = crc_state[0] ? ((crc_state >> 1) ^ rpoly)
                                                 : (crc_state >> 1);
                    end
                end else begin
                    crc_state ^= {byte_if.data_byte, 24'h0};
                    for (int k = 0; k < crc32e_pkg::BYTE_W; k++) begin
                        crc_state = crc_state[crc32e_pkg::CRC_W-1]
                                  ? ((crc_state << 1) ^ cfg_shadow.polynomial)
                                  : (crc_state << 1);
                    end
                end
                if (byte_if.last_byte) begin
                    sum = (cfg_shadow.reflect_in != cfg_shadow.reflect_out)
                        ? mirror32(crc_state) : crc_state;
                    checksum_due.push_back(sum ^ cfg_shadow.xor_out);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    crc32e_pkg::CFG_POLYNOMIAL:  cfg_shadow.polynomial  = i_cfg_data;
                    crc32e_pkg::CFG_REFLECT_IN:  cfg_shadow.reflect_in  = i_cfg_data[0];
                    crc32e_pkg::CFG_REFLECT_OUT: cfg_shadow.reflect_out = i_cfg_data[0];
                    crc32e_pkg::CFG_START_VALUE: cfg_shadow.start_value = i_cfg_data;
                    crc32e_pkg::CFG_XOR_OUT:     cfg_shadow.xor_out     = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Compare each delivered checksum with the oldest prediction
    always @(posedge i_clk) begin : checksum_checker
        logic [crc32e_pkg::CRC_W-1:0] want;
        if (i_rst_n && crc_if.valid && crc_if.ready) begin
            checksums_seen++;
            if (checksum_due.size() == 0) begin
                $error("checksum: expected none, got %h", crc_if.checksum);
                mismatches++;
            end else begin
                want = checksum_due.pop_front();
                if (crc_if.checksum !== want) begin
                    $error("checksum: expected %h, got %h", want, crc_if.checksum);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random pacing, plus a long hold-off on request
    initial begin : sink_pacing
        t_pace mode;
        int    span;
        int    hold;
        crc_if.ready = 1'b0;
        mode = PACE_OPEN;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                crc_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = t_pace'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    PACE_OPEN:   crc_if.ready <= 1'b1;
                    PACE_MOSTLY: crc_if.ready <= ($urandom_range(0, 3) != 0);
                    PACE_SPARSE: crc_if.ready <= ($urandom_range(0, 3) == 0);
                    default:     crc_if.ready <= span[2];
                endcase
            end
        end
    end

    // Offer one byte; with sender_gaps set, bursts of random length separated by random gaps
    task automatic send_byte(input logic [crc32e_pkg::BYTE_W-1:0] value, input logic first,
                             input logic last);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                byte_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= value;
        byte_if.first_byte <= first;
        byte_if.last_byte  <= last;
        do @(posedge i_clk); while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic send_message(input int len, input bit mark_first, input bit mark_last);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), mark_first && i == 0, mark_last && i == len - 1);
        end
    endtask

    // Stop offering, let every owed checksum arrive and the fold settle
    task automatic wait_crc_idle();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (checksum_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input crc32e_pkg::t_cfg_index idx,
                             input logic [crc32e_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // Flag registers get random upper bits; only bit 0 counts
    task automatic apply_config(input crc32e_pkg::t_cfg c);
        write_reg(crc32e_pkg::CFG_POLYNOMIAL, c.polynomial);
        write_reg(crc32e_pkg::CFG_REFLECT_IN, ($urandom & 32'hFFFF_FFFE) | c.reflect_in);
        write_reg(crc32e_pkg::CFG_REFLECT_OUT, ($urandom & 32'hFFFF_FFFE) | c.reflect_out);
        write_reg(crc32e_pkg::CFG_START_VALUE, c.start_value);
        write_reg(crc32e_pkg::CFG_XOR_OUT, c.xor_out);
    endtask

    // Register starts from its reset value when no first mark was seen
    task automatic test_no_first_after_reset();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_single_byte_messages();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b1);
    endtask

    // Bytes after a last mark keep folding into the same register
    task automatic test_continue_after_last();
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
        send_byte(8'hC3, 1'b0, 1'b1);
    endtask

    // Switch to reflected input between two bytes of one message
    task automatic test_config_mid_message();
        send_byte(8'h31, 1'b1, 1'b0);
        wait_crc_idle();
        write_reg(crc32e_pkg::CFG_REFLECT_IN, 32'h1);
        send_byte(8'h32, 1'b0, 1'b1);
        wait_crc_idle();
        write_reg(crc32e_pkg::CFG_REFLECT_IN, 32'h0);
    endtask

    // Writes to indexes past the register list must change nothing
    task automatic test_unused_index();
        wait_crc_idle();
        for (int i = int'(crc32e_pkg::CFG_XOR_OUT) + 1; i <= int'(CFG_INDEX_TOP); i++) begin
            write_reg(crc32e_pkg::t_cfg_index'(i), $urandom);
        end
        send_byte(8'h7E, 1'b1, 1'b1);
        send_byte(8'h81, 1'b1, 1'b1);
    endtask

    // Receiver holds off while one-byte messages keep coming, then drain
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        stall_request = 300;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'($urandom), 1'b1, 1'b1);
        end
        wait_crc_idle();
        sender_gaps = 1'b1;
    endtask

    // Mostly well-formed messages under a series of settings, with some noise
    task automatic test_random_traffic();
        crc32e_pkg::t_cfg settings[CONFIG_SETS];
        int               target;
        int               pick;
        int               len;
        settings[0] = make_cfg(crc32e_pkg::POLY_RESET, 1'b0, 1'b0,
                               crc32e_pkg::START_RESET, crc32e_pkg::XOR_RESET);
        settings[1] = make_cfg(32'h0, 1'b0, 1'b0, 32'h0, 32'h0);
        settings[2] = make_cfg('1, 1'b1, 1'b1, '1, '1);
        settings[3] = make_cfg(32'h04C1_1DB7, 1'b1, 1'b1, '1, '1);
        settings[4] = make_cfg(32'h1EDC_6F41, 1'b0, 1'b1, '1, 32'h0);
        settings[5] = make_cfg(32'h8000_0001, 1'b1, 1'b0, 32'h0, '1);
        settings[6] = make_cfg($urandom, 1'($urandom), 1'($urandom), $urandom, $urandom);
        settings[7] = make_cfg($urandom, 1'($urandom), 1'($urandom), $urandom, $urandom);
        for (int s = 0; s < CONFIG_SETS; s++) begin
            wait_crc_idle();
            apply_config(settings[s]);
            sender_gaps = (s != 6);
            target = bytes_sent + BYTES_PER_SET;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                len = $urandom_range(0, 99);
                len = (len < 70) ? $urandom_range(1, 8)
                    : (len < 95) ? $urandom_range(9, 32) : $urandom_range(33, 64);
                if (pick < 80) begin
                    send_message(len, 1'b1, 1'b1);
                end else if (pick < 88) begin
                    send_message(len, 1'b0, 1'b1);
                end else if (pick < 94) begin
                    send_message(len, 1'b1, 1'b0);
                end else begin
                    send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = crc32e_pkg::CFG_POLYNOMIAL;
        i_cfg_data         = '0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.first_byte = 1'b0;
        byte_if.last_byte  = 1'b0;
        bytes_sent         = 0;
        checksums_seen     = 0;
        cfg_writes         = 0;
        mismatches         = 0;
        burst_left         = 0;
        stall_request      = 0;
        sender_gaps        = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_first_after_reset();
        test_byte_extremes();
        test_single_byte_messages();
        test_continue_after_last();
        test_config_mid_message();
        test_unused_index();
        test_backpressure();
        test_random_traffic();
        wait_crc_idle();

        if (checksum_due.size() != 0) begin
            $error("checksum: %0d expected results never arrived", checksum_due.size());
            mismatches++;
        end

        $display("Run covered %0d bytes, %0d checksums, %0d register writes over %0d settings,",
                 bytes_sent, checksums_seen, cfg_writes, CONFIG_SETS);
        $display("including mid-message reconfiguration and a long receiver hold-off.");
        if (mismatches == 0) begin
            $display("crc32_configurable_engine_tb: PASS");
        end else begin
            $display("crc32_configurable_engine_tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/crc32e_pkg.sv
hw/rtl/crc32e_if.sv
hw/rtl/crc32e_cfg.sv
hw/rtl/crc32e_fold.sv
hw/rtl/crc32_configurable_engine.sv
hw/rtl/crc32e_checker.sv
bench/crc32_configurable_engine_tb.sv
